### rtl/sgpa_pkg.sv
// Shared types and constants of the streaming graph partition assigner.
// Holds the beat structs, the cell control and chain structs and the config register codes.
// No dependencies.
package sgpa_pkg;

	localparam int VID_W     = 12;
	localparam int WT_W      = 16;
	localparam int PW_W      = 28;
	localparam int INTER_W   = 32;
	localparam int ALPHA_W   = 32;
	localparam int PIDX_W    = 6;   // wide enough for the largest partition count
	localparam int NUSE_W    = 7;
	localparam int SQ_W      = 46;  // radicand width of the square root unit
	localparam int ROOT_W    = 23;
	localparam int ISQ_ITERS = 23;
	localparam int SCORE_W   = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [PW_W-1:0] PW_MAX = {PW_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_PARTS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd2;

	localparam logic ACT_NEIGHBOR = 1'b0;
	localparam logic ACT_CLEAR    = 1'b1;

	typedef struct packed {
		logic             action;
		logic [VID_W-1:0] vertex_id;
		logic [WT_W-1:0]  vtx_wt;
		logic [VID_W-1:0] neighbor_id;
		logic [WT_W-1:0]  edge_wt;
		logic             has_neighbor;
		logic             last;
	} in_beat_t;

	typedef struct packed {
		logic [VID_W-1:0] placed_vertex;
		logic [2:0]       chosen_part;
		logic             limit_dropped;
	} out_beat_t;

	typedef struct packed {
		logic               clr;
		logic               acc;
		logic [PIDX_W-1:0]  acc_idx;
		logic [WT_W-1:0]    ew;
		logic               start;
		logic [WT_W-1:0]    v;
		logic [PW_W-1:0]    cap;
		logic               limit_act;
		logic [NUSE_W-1:0]  n_use;
		logic [ALPHA_W-1:0] alpha;
		logic               upd;
		logic               old_ok;
		logic [PIDX_W-1:0]  old_idx;
		logic [PIDX_W-1:0]  ch_idx;
	} cell_ctl_t;

	typedef struct packed {
		logic                      lim_ok;
		logic [PIDX_W-1:0]         lim_idx;
		logic signed [SCORE_W-1:0] lim_score;
		logic                      any_ok;
		logic [PIDX_W-1:0]         any_idx;
		logic signed [SCORE_W-1:0] any_score;
	} chain_t;

endpackage

### rtl/streaming_graph_partition_assign_core.sv
// Streaming graph partition assigner: top level with sequencer, vertex table and cell row.
// Depends on sgpa_pkg and sgpa_cell.
//
// Each neighbor beat passes through accept, table read and accumulate. A last beat adds the
// scoring: both square roots run in every cell, then the score pipeline, and the best
// candidate ripples through the row of MAX_PARTS cells before the decision and the update.
// After reset and after every clear beat the vertex table is swept one entry per cycle,
// during which no beat is accepted. Results leave through an output register, so a waiting
// result does not hold off the next beat, but the next placement waits in its update step until it is taken.
module streaming_graph_partition_assign_core #(
	parameter int MAX_VERTICES = 4096,
	parameter int MAX_PARTS    = 8,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  sgpa_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output sgpa_pkg::out_beat_t                 out_data,
	input  logic                                cfg_we,
	input  logic [sgpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sgpa_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int PB = $clog2(MAX_PARTS);
	localparam int EW = PB + 1;
	localparam int SCORE_CYCLES = sgpa_pkg::ISQ_ITERS + 6 + MAX_PARTS;
	localparam int CW = $clog2(SCORE_CYCLES + 1);
	localparam logic [sgpa_pkg::WT_W-1:0] WMASK = (WEIGHT_BITS >= sgpa_pkg::WT_W) ? '1
		: sgpa_pkg::WT_W'((32'd1 << WEIGHT_BITS) - 32'd1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_NB_RD, ST_NB_ACC, ST_SC_START, ST_SCORE, ST_DECIDE, ST_UPDATE
	} state_t;

	state_t                           state_q;
	sgpa_pkg::in_beat_t               item_q;
	logic [AW-1:0]                    clr_q;
	logic [CW-1:0]                    cnt_q;
	logic [3:0]                       parts_q;
	logic [sgpa_pkg::PW_W-1:0]        cap_q;
	logic [sgpa_pkg::ALPHA_W-1:0]     alpha_q;
	logic                             limit_off_q;
	logic [PB-1:0]                    ch_q;
	logic                             out_valid_q;
	sgpa_pkg::out_beat_t              out_q;

	logic [EW-1:0]                    mem [MAX_VERTICES];
	logic [EW-1:0]                    rd_q;
	logic                             mem_we, mem_re;
	logic [AW-1:0]                    mem_wa, mem_ra;
	logic [EW-1:0]                    mem_wd;

	logic [sgpa_pkg::NUSE_W-1:0]      n_use;
	logic                             vid_ok, nid_ok, out_free;
	logic [sgpa_pkg::WT_W-1:0]        v_m;
	sgpa_pkg::cell_ctl_t              ctl;
	sgpa_pkg::chain_t                 chain [MAX_PARTS+1];

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign vid_ok = 32'(item_q.vertex_id) < MAX_VERTICES;
	assign nid_ok = 32'(item_q.neighbor_id) < MAX_VERTICES;
	assign v_m    = item_q.vtx_wt & WMASK;
	assign n_use  = (parts_q == 4'd0) ? sgpa_pkg::NUSE_W'(1)
		: ((32'(parts_q) > MAX_PARTS) ? sgpa_pkg::NUSE_W'(MAX_PARTS)
		: sgpa_pkg::NUSE_W'(parts_q));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = AW'(item_q.neighbor_id);
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_NB_RD: mem_re = 1'b1;
			ST_SC_START: begin
				mem_re = 1'b1;
				mem_ra = AW'(item_q.vertex_id);
			end
			ST_UPDATE: begin
				mem_we = out_free && vid_ok;
				mem_wa = AW'(item_q.vertex_id);
				mem_wd = {1'b1, ch_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem[mem_ra];
	end

	always_comb begin
		ctl           = '0;
		ctl.clr       = state_q == ST_CLEAR;
		ctl.acc       = state_q == ST_NB_ACC && item_q.has_neighbor && nid_ok && rd_q[PB];
		ctl.acc_idx   = sgpa_pkg::PIDX_W'(rd_q[PB-1:0]);
		ctl.ew        = item_q.edge_wt & WMASK;
		ctl.start     = state_q == ST_SC_START;
		ctl.v         = v_m;
		ctl.cap       = cap_q;
		ctl.limit_act = cap_q != '0 && !limit_off_q;
		ctl.n_use     = n_use;
		ctl.alpha     = alpha_q;
		ctl.upd       = state_q == ST_UPDATE && out_free;
		ctl.old_ok    = vid_ok && rd_q[PB];
		ctl.old_idx   = sgpa_pkg::PIDX_W'(rd_q[PB-1:0]);
		ctl.ch_idx    = sgpa_pkg::PIDX_W'(ch_q);
	end

	assign chain[0] = '0;

	for (genvar k = 0; k < MAX_PARTS; k++) begin : g_cell
		sgpa_cell #(.CELL_IDX(k)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.chain_in(chain[k]), .chain_out(chain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parts_q <= 4'd8;
			cap_q   <= '0;
			alpha_q <= 32'h0100_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				sgpa_pkg::CFG_PARTS:    parts_q <= cfg_wdata[3:0];
				sgpa_pkg::CFG_CAPACITY: cap_q   <= cfg_wdata[sgpa_pkg::PW_W-1:0];
				sgpa_pkg::CFG_ALPHA:    alpha_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			limit_off_q <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_UPDATE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == MAX_VERTICES - 1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.action == sgpa_pkg::ACT_CLEAR) begin
							clr_q       <= '0;
							limit_off_q <= 1'b0;
							state_q     <= ST_CLEAR;
						end else begin
							state_q <= ST_NB_RD;
						end
					end
				end
				ST_NB_RD: state_q <= ST_NB_ACC;
				ST_NB_ACC: state_q <= item_q.last ? ST_SC_START : ST_IDLE;
				ST_SC_START: begin
					cnt_q   <= CW'(SCORE_CYCLES);
					state_q <= ST_SCORE;
				end
				ST_SCORE: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					// No partition fits: drop the limit for the rest of the pass.
					if (chain[MAX_PARTS].lim_ok) begin
						ch_q <= chain[MAX_PARTS].lim_idx[PB-1:0];
					end else begin
						ch_q        <= chain[MAX_PARTS].any_idx[PB-1:0];
						limit_off_q <= 1'b1;
					end
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			item_q <= in_data;
		if (state_q == ST_UPDATE && out_free) begin
			out_q.placed_vertex <= item_q.vertex_id;
			out_q.chosen_part   <= 3'(ch_q);
			out_q.limit_dropped <= limit_off_q;
		end
	end

	a_mem_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("vertex table written and read in the same cycle");

	a_choice_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> {1'b0, sgpa_pkg::PIDX_W'(ch_q)} < n_use)
		else $error("chosen partition is not in use");

	a_limit_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(limit_off_q) |-> $past(state_q) == ST_DECIDE)
		else $error("limit dropped outside a placement decision");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && out_free) |=> out_valid && state_q == ST_IDLE)
		else $error("placement did not produce a result beat");

endmodule

### rtl/sgpa_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Used by each partition cell; depends on sgpa_pkg.
module sgpa_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sgpa_pkg::SQ_W-1:0]     x,
	output logic [sgpa_pkg::ROOT_W-1:0]   root
);

	logic [sgpa_pkg::SQ_W-1:0] rem_q, res_q, bit_q;
	logic [sgpa_pkg::SQ_W-1:0] trial;

	assign trial = res_q + bit_q;
	assign root  = res_q[sgpa_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			rem_q <= '0;
			res_q <= '0;
		end else if (start) begin
			rem_q <= x;
			res_q <= '0;
			bit_q <= sgpa_pkg::SQ_W'(1) << (sgpa_pkg::SQ_W - 2);
		end else if (bit_q != '0) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

### rtl/sgpa_cell.sv
// One partition cell: holds its weight and neighbor sum, scores itself and
// passes the best candidate so far to the next cell. Depends on sgpa_pkg, sgpa_isqrt.
module sgpa_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sgpa_pkg::cell_ctl_t ctl,
	input  sgpa_pkg::chain_t    chain_in,
	output sgpa_pkg::chain_t    chain_out
);

	localparam logic [sgpa_pkg::PIDX_W-1:0] ME = sgpa_pkg::PIDX_W'(CELL_IDX);

	logic [sgpa_pkg::PW_W-1:0]    w_q;
	logic [sgpa_pkg::INTER_W-1:0] inter_q;
	logic [sgpa_pkg::PW_W:0]      xa, xb;
	logic [sgpa_pkg::ROOT_W-1:0]  ra, rb;
	logic [51:0]                  fa_s1, fb_s1, d_s2;
	logic [51:0]                  phi_s3;
	logic [63:0]                  plo_s3;
	logic signed [63:0]           score_s4;
	logic [60:0]                  pen;
	logic                         in_use, fits;
	logic [sgpa_pkg::INTER_W:0]   inter_sum;
	logic [sgpa_pkg::PW_W-1:0]    w_rem;
	logic [sgpa_pkg::PW_W:0]      w_add;
	logic [sgpa_pkg::WT_W-1:0]    v_add;
	sgpa_pkg::chain_t             nxt;

	assign xa = {1'b0, w_q} + (sgpa_pkg::PW_W+1)'(ctl.v);
	assign xb = {1'b0, w_q};

	sgpa_isqrt u_sqa (
		.clk(clk), .arst_n(arst_n), .start(ctl.start),
		.x({1'b0, xa, 16'b0}), .root(ra)
	);
	sgpa_isqrt u_sqb (
		.clk(clk), .arst_n(arst_n), .start(ctl.start),
		.x({1'b0, xb, 16'b0}), .root(rb)
	);

	// Score pipeline runs free; its inputs hold still while the sequencer waits.
	always_ff @(posedge clk) begin
		fa_s1    <= 52'(xa) * 52'(ra);
		fb_s1    <= 52'(xb) * 52'(rb);
		d_s2     <= fa_s1 - fb_s1;
		phi_s3   <= 52'(d_s2[51:32]) * 52'(ctl.alpha);
		plo_s3   <= 64'(d_s2[31:0]) * 64'(ctl.alpha);
		score_s4 <= $signed({24'b0, inter_q, 8'b0}) - $signed({3'b0, pen});
	end

	assign pen = 61'({phi_s3[51:0], 8'b0}) + 61'(plo_s3 >> 24);

	assign in_use = {1'b0, ME} < ctl.n_use;
	assign fits   = !ctl.limit_act || (xa <= {1'b0, ctl.cap});

	always_comb begin
		nxt = chain_in;
		if (in_use && (!chain_in.any_ok || score_s4 > chain_in.any_score)) begin
			nxt.any_ok    = 1'b1;
			nxt.any_idx   = ME;
			nxt.any_score = score_s4;
		end
		if (in_use && fits && (!chain_in.lim_ok || score_s4 > chain_in.lim_score)) begin
			nxt.lim_ok    = 1'b1;
			nxt.lim_idx   = ME;
			nxt.lim_score = score_s4;
		end
	end

	assign inter_sum = {1'b0, inter_q} + (sgpa_pkg::INTER_W+1)'(ctl.ew);
	assign w_rem = (ctl.old_ok && ctl.old_idx == ME)
		? ((w_q > sgpa_pkg::PW_W'(ctl.v)) ? w_q - sgpa_pkg::PW_W'(ctl.v) : '0) : w_q;
	assign v_add = (ctl.ch_idx == ME) ? ctl.v : '0;
	assign w_add = {1'b0, w_rem} + (sgpa_pkg::PW_W+1)'(v_add);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= '0;
			inter_q   <= '0;
			chain_out <= '0;
		end else begin
			chain_out <= nxt;
			if (ctl.clr) begin
				w_q     <= '0;
				inter_q <= '0;
			end else if (ctl.upd) begin
				w_q     <= w_add[sgpa_pkg::PW_W] ? sgpa_pkg::PW_MAX : w_add[sgpa_pkg::PW_W-1:0];
				inter_q <= '0;
			end else if (ctl.acc && ctl.acc_idx == ME) begin
				inter_q <= inter_sum[sgpa_pkg::INTER_W] ? '1
					: inter_sum[sgpa_pkg::INTER_W-1:0];
			end
		end
	end

endmodule

### tb/testbench.sv
// Self-checking testbench for streaming_graph_partition_assign_core.
// Drives vertex runs and clear beats with random gaps and output stalls, predicts each placement
// with its own scoring model, and checks results in order. Depends on sgpa_pkg and the RTL.
module testbench;

	localparam int NV = 4096;
	localparam int NP = 8;
	localparam int WDOG_LIMIT = 30000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sgpa_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sgpa_pkg::out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [sgpa_pkg::CFG_IDX_W-1:0] cfg_index = sgpa_pkg::CFG_PARTS;
	logic [sgpa_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

	streaming_graph_partition_assign_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the partitioner state.
	bit              placed_ok [NV];
	bit [2:0]        placed_in [NV];
	longint unsigned part_load [NP];
	longint unsigned link_sum [NP];
	bit              cap_dropped;
	int unsigned     m_parts = 8;
	longint unsigned m_cap = 0;
	longint unsigned m_alpha = 64'd16777216;

	sgpa_pkg::in_beat_t  pending_beats[$];
	sgpa_pkg::out_beat_t placements_due[$];
	int errors = 0;
	int beats_in = 0;
	int placements_seen = 0;
	int clears_sent = 0;
	int drops_seen = 0;
	bit gaps_on = 1'b1;
	int long_hold_req = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned pow_3_2(input longint unsigned x);
		return x * int_sqrt(x << 16);
	endfunction

	function automatic longint part_score(input int p, input longint unsigned v);
		longint unsigned d, pen;
		d = pow_3_2(part_load[p] + v) - pow_3_2(part_load[p]);
		pen = (((d >> 32) * m_alpha) << 8) + (((d & 64'hFFFF_FFFF) * m_alpha) >> 24);
		return longint'(link_sum[p] << 8) - longint'(pen);
	endfunction

	function automatic int best_part(input int n, input longint unsigned v, input bit capped);
		int best = -1;
		longint best_s = 0;
		longint s;
		for (int p = 0; p < n; p++) begin
			if (capped && part_load[p] + v > m_cap) continue;
			s = part_score(p, v);
			if (best < 0 || s > best_s) begin
				best = p;
				best_s = s;
			end
		end
		return best;
	endfunction

	function automatic void place_beat(input sgpa_pkg::in_beat_t b);
		int n, ch;
		longint unsigned v, s;
		sgpa_pkg::out_beat_t o;
		v = b.vtx_wt;
		if (b.action == sgpa_pkg::ACT_CLEAR) begin
			foreach (placed_ok[i]) placed_ok[i] = 1'b0;
			foreach (part_load[i]) begin
				part_load[i] = 0;
				link_sum[i] = 0;
			end
			cap_dropped = 1'b0;
			return;
		end
		if (b.has_neighbor && placed_ok[b.neighbor_id]) begin
			s = link_sum[placed_in[b.neighbor_id]] + b.edge_wt;
			link_sum[placed_in[b.neighbor_id]] = (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
		end
		if (!b.last) return;
		n = (m_parts == 0) ? 1 : ((m_parts > NP) ? NP : m_parts);
		ch = best_part(n, v, m_cap != 0 && !cap_dropped);
		if (ch < 0) begin
			cap_dropped = 1'b1;
			ch = best_part(n, v, 1'b0);
		end
		if (ch < 0) ch = 0;
		if (placed_ok[b.vertex_id]) begin
			s = part_load[placed_in[b.vertex_id]];
			part_load[placed_in[b.vertex_id]] = (s > v) ? s - v : 0;
		end
		placed_ok[b.vertex_id] = 1'b1;
		placed_in[b.vertex_id] = ch[2:0];
		s = part_load[ch] + v;
		part_load[ch] = (s > 64'(sgpa_pkg::PW_MAX)) ? 64'(sgpa_pkg::PW_MAX) : s;
		foreach (link_sum[i]) link_sum[i] = 0;
		o.placed_vertex = b.vertex_id;
		o.chosen_part = ch[2:0];
		o.limit_dropped = cap_dropped;
		placements_due = {placements_due, o};
	endfunction

	// Acceptance on both channels, result checking and the stall watchdog.
	bit in_took = 1'b0;
	bit out_took = 1'b0;
	int idle_cycles = 0;
	always @(posedge clk) begin
		in_took = in_valid && in_ready;
		out_took = out_valid && out_ready;
		if (in_took) begin
			place_beat(in_data);
			beats_in++;
		end
		if (out_took) begin
			placements_seen++;
			if (placements_due.size() == 0) begin
				report("unexpected result, vertex", out_data.placed_vertex, -1);
			end else begin
				if (out_data.placed_vertex != placements_due[0].placed_vertex)
					report("placed_vertex", out_data.placed_vertex,
						placements_due[0].placed_vertex);
				if (out_data.chosen_part != placements_due[0].chosen_part)
					report("chosen_part", out_data.chosen_part, placements_due[0].chosen_part);
				if (out_data.limit_dropped != placements_due[0].limit_dropped)
					report("limit_dropped", out_data.limit_dropped,
						placements_due[0].limit_dropped);
				if (out_data.limit_dropped) drops_seen++;
				void'(placements_due.pop_front());
			end
		end
		idle_cycles = (in_took || out_took) ? 0 : idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", WDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Sender: one beat at a time from the pending queue, random gap between beats when gaps are on.
	int send_gap = 0;
	always @(negedge clk) begin
		logic nv;
		nv = in_valid;
		if (in_valid && in_took) begin
			nv = 1'b0;
			send_gap = gaps_on ? $urandom_range(9, 0) : 0;
		end
		if (!nv) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_beats.size() != 0) begin
				in_data <= pending_beats.pop_front();
				nv = 1'b1;
			end
		end
		in_valid <= nv;
	end

	// Receiver: random stall per result when gaps are on, plus a long hold-off when requested.
	int recv_gap = 0;
	int hold_left = 0;
	int holds_done = 0;
	always @(negedge clk) begin
		if (holds_done != long_hold_req) begin
			holds_done = long_hold_req;
			hold_left = 400;
		end
		if (out_took) recv_gap = gaps_on ? $urandom_range(9, 0) : 0;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic push_beat(input logic act, input int vid, input int vw, input int nid,
			input int ew, input logic hn, input logic lst);
		sgpa_pkg::in_beat_t b;
		b.action = act;
		b.vertex_id = sgpa_pkg::VID_W'(vid);
		b.vtx_wt = sgpa_pkg::WT_W'(vw);
		b.neighbor_id = sgpa_pkg::VID_W'(nid);
		b.edge_wt = sgpa_pkg::WT_W'(ew);
		b.has_neighbor = hn;
		b.last = lst;
		pending_beats = {pending_beats, b};
	endtask

	task automatic push_vertex(input int vid, input int vw, input int k, input int id_span);
		if (k == 0) begin
			push_beat(sgpa_pkg::ACT_NEIGHBOR, vid, vw, $urandom_range(4095, 0),
				$urandom_range(65535, 0), 1'b0, 1'b1);
		end else begin
			for (int i = 0; i < k; i++)
				push_beat(sgpa_pkg::ACT_NEIGHBOR, (i == k - 1) ? vid : $urandom_range(4095, 0),
					(i == k - 1) ? vw : $urandom_range(65535, 0),
					$urandom_range(id_span, 0),
					($urandom_range(9, 0) == 0) ? 65535 : $urandom_range(300, 0),
					($urandom_range(7, 0) != 0), i == k - 1);
		end
	endtask

	task automatic write_reg(input logic [sgpa_pkg::CFG_IDX_W-1:0] idx,
			input longint unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[31:0];
		case (idx)
			sgpa_pkg::CFG_PARTS: m_parts = 32'(val & 64'hF);
			sgpa_pkg::CFG_CAPACITY: m_cap = val & 64'(sgpa_pkg::PW_MAX);
			default: m_alpha = val & 64'hFFFF_FFFF;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Everything sent has been accepted and every placement has come back.
	task automatic drain();
		while (pending_beats.size() != 0 || in_valid || placements_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_phase(input int beats, input int id_span, input int wt_max);
		int stop;
		stop = beats_in + beats;
		while (beats_in + pending_beats.size() < stop) begin
			case ($urandom_range(19, 0))
				0: push_beat(sgpa_pkg::ACT_NEIGHBOR, $urandom_range(4095, 0),
						$urandom_range(65535, 0), $urandom_range(4095, 0),
						$urandom_range(65535, 0), 1'($urandom_range(1, 0)), 1'b0);
				1: push_vertex($urandom_range(4095, 0), $urandom_range(65535, 0),
						$urandom_range(4, 0), 4095);
				default: push_vertex($urandom_range(id_span, 0), $urandom_range(wt_max, 0),
						$urandom_range(5, 0), id_span);
			endcase
		end
	endtask

	initial begin
		foreach (placed_ok[i]) placed_ok[i] = 1'b0;
		foreach (part_load[i]) begin
			part_load[i] = 0;
			link_sum[i] = 0;
		end
		cap_dropped = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: vertex with no edges, self loop, heavy edges and weights, re-placement, clear.
		push_vertex(0, 0, 0, 0);
		push_vertex(1, 65535, 0, 0);
		push_beat(sgpa_pkg::ACT_NEIGHBOR, 2, 10, 0, 65535, 1'b1, 1'b0);
		push_beat(sgpa_pkg::ACT_NEIGHBOR, 2, 10, 1, 65535, 1'b1, 1'b0);
		push_beat(sgpa_pkg::ACT_NEIGHBOR, 2, 10, 4095, 1, 1'b1, 1'b1);
		push_beat(sgpa_pkg::ACT_NEIGHBOR, 1, 65535, 1, 65535, 1'b1, 1'b1);
		push_beat(sgpa_pkg::ACT_NEIGHBOR, 4095, 1, 2, 500, 1'b1, 1'b0);
		push_beat(sgpa_pkg::ACT_NEIGHBOR, 4095, 1, 2, 0, 1'b0, 1'b1);
		push_beat(sgpa_pkg::ACT_NEIGHBOR, 2, 300, 4095, 65535, 1'b1, 1'b1);
		push_beat(sgpa_pkg::ACT_CLEAR, 4095, 65535, 4095, 65535, 1'b1, 1'b1);
		push_vertex(3, 7, 0, 0);
		push_beat(sgpa_pkg::ACT_NEIGHBOR, 0, 0, 3, 65535, 1'b1, 1'b1);
		drain();

		// Several settings, extremes included; the limit is tight in some to force dropping.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_reg(sgpa_pkg::CFG_PARTS, 8);
					write_reg(sgpa_pkg::CFG_CAPACITY, 0);
					write_reg(sgpa_pkg::CFG_ALPHA, 32'h0100_0000); end
				1: begin write_reg(sgpa_pkg::CFG_PARTS, 4);
					write_reg(sgpa_pkg::CFG_CAPACITY, 3000);
					write_reg(sgpa_pkg::CFG_ALPHA, 32'h0004_0000); end
				2: begin write_reg(sgpa_pkg::CFG_PARTS, 1);
					write_reg(sgpa_pkg::CFG_CAPACITY, 500);
					write_reg(sgpa_pkg::CFG_ALPHA, 0); end
				3: begin write_reg(sgpa_pkg::CFG_PARTS, 15);
					write_reg(sgpa_pkg::CFG_CAPACITY, 64'(sgpa_pkg::PW_MAX));
					write_reg(sgpa_pkg::CFG_ALPHA, 32'hFFFF_FFFF); end
				4: begin write_reg(sgpa_pkg::CFG_PARTS, 0);
					write_reg(sgpa_pkg::CFG_CAPACITY, 1);
					write_reg(sgpa_pkg::CFG_ALPHA, 32'h0000_0001); end
				5: begin write_reg(sgpa_pkg::CFG_PARTS, 3);
					write_reg(sgpa_pkg::CFG_CAPACITY, 200000);
					write_reg(sgpa_pkg::CFG_ALPHA, 32'h0080_0000); end
				6: begin write_reg(sgpa_pkg::CFG_PARTS, 8);
					write_reg(sgpa_pkg::CFG_CAPACITY, 20000);
					write_reg(sgpa_pkg::CFG_ALPHA, 32'h0000_4000); end
				default: begin write_reg(sgpa_pkg::CFG_PARTS, 6);
					write_reg(sgpa_pkg::CFG_CAPACITY, 0);
					write_reg(sgpa_pkg::CFG_ALPHA, 32'h2000_0000); end
			endcase
			gaps_on = (ph % 3 != 2);
			if (ph == 2 || ph == 5) long_hold_req++;
			if (ph == 4 || ph == 6) push_beat(sgpa_pkg::ACT_CLEAR, $urandom_range(4095, 0),
				$urandom_range(65535, 0), $urandom_range(4095, 0), $urandom_range(65535, 0),
				1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
			random_phase(100, (ph == 3) ? 4095 : 63, (ph % 2 == 0) ? 65535 : 2000);
			drain();
		end

		$display("run covered %0d input beats, %0d placements (%0d with the limit dropped),",
			beats_in, placements_seen, drops_seen);
		$display("eight register settings and clears; %0d mismatches", errors);
		if (errors == 0 && placements_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
